// ----- design/kpsd_pkg.sv -----
package kpsd_pkg;

	// Key codes that count as arrows in the pad block
	localparam logic [5:0] ARROW_A = 6'h0D;
	localparam logic [5:0] ARROW_B = 6'h08;
	localparam logic [5:0] ARROW_C = 6'h06;
	localparam logic [5:0] ARROW_D = 6'h02;

	// Configuration register indexes
	localparam logic [1:0] REG_PAD_PREFIX = 2'd0;
	localparam logic [1:0] REG_SHIFT      = 2'd1;
	localparam logic [1:0] REG_PAD_OFFSET = 2'd2;
	localparam logic [1:0] REG_CALC_OFFSET = 2'd3;

	// One decoded item: up to three events, slot 0 first.
	// count 0 means a single result with no event.
	typedef struct packed {
		logic [2:0][7:0] code;
		logic [2:0]      rel;
		logic [1:0]      count;
		logic            status;
	} kpsd_entry_t;

	// Queue status toward the back end
	typedef struct packed {
		logic empty;
		logic full;
	} kpsd_qstat_t;

endpackage

// ----- design/kpsd_if.sv -----
interface kpsd_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] wire_byte;

	modport source(output valid, output req_type, output wire_byte, input ready);
	modport sink(input valid, input req_type, input wire_byte, output ready);
endinterface

interface kpsd_rsp_if;
	logic       valid;
	logic       ready;
	logic       has_event;
	logic [7:0] key_code;
	logic       is_release;
	logic       status;
	logic       last;

	modport source(output valid, output has_event, output key_code, output is_release,
		output status, output last, input ready);
	modport sink(input valid, input has_event, input key_code, input is_release,
		input status, input last, output ready);
endinterface

// ----- design/kpsd_front.sv -----
module kpsd_front (
	input  logic                clk,
	input  logic                arst_n,
	kpsd_req_if.sink            req,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	input  kpsd_pkg::kpsd_qstat_t qstat,
	output logic                push,
	output kpsd_pkg::kpsd_entry_t push_data
);
	import kpsd_pkg::*;

	localparam logic [1:0] ST_START     = 2'd0;
	localparam logic [1:0] ST_PAD       = 2'd1;
	localparam logic [1:0] ST_SHIFT     = 2'd2;
	localparam logic [1:0] ST_SHIFT_PAD = 2'd3;

	logic [6:0] pad_prefix_q;
	logic [6:0] shift_val_q;
	logic [7:0] pad_off_q;
	logic [7:0] calc_off_q;
	logic [1:0] stage_q, stage_d;
	logic [7:0] held_q, held_d;

	logic [5:0] c;
	logic       rel;
	logic       is_pad, is_shift, arrow;
	logic [7:0] pad_code, calc_code, shift_code;
	kpsd_entry_t ent;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_prefix_q <= 7'd121;
			shift_val_q  <= 7'd113;
			pad_off_q    <= 8'd64;
			calc_off_q   <= 8'd128;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAD_PREFIX:  pad_prefix_q <= cfg_wdata[6:0];
				REG_SHIFT:       shift_val_q  <= cfg_wdata[6:0];
				REG_PAD_OFFSET:  pad_off_q    <= cfg_wdata;
				REG_CALC_OFFSET: calc_off_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign req.ready = !qstat.full;
	assign push      = req.valid && req.ready;
	assign push_data = ent;

	// Byte classification
	assign c          = req.wire_byte[6:1];
	assign rel        = req.wire_byte[7];
	assign is_pad     = req.wire_byte[6:0] == pad_prefix_q;
	assign is_shift   = req.wire_byte[6:0] == shift_val_q;
	assign arrow      = c inside {ARROW_A, ARROW_B, ARROW_C, ARROW_D};
	assign pad_code   = 8'(pad_off_q + {2'b00, c});
	assign calc_code  = 8'(calc_off_q + {2'b00, c});
	assign shift_code = {2'b00, held_q[6:1]};

	// Decode one item into its event list and next state
	always_comb begin
		ent     = '0;
		stage_d = stage_q;
		held_d  = held_q;
		if (req.req_type) begin
			if (stage_q[1]) begin
				ent.code[0] = shift_code;
				ent.rel[0]  = held_q[7];
				ent.count   = 2'd1;
			end
			stage_d    = ST_START;
			ent.status = 1'b1;
		end else begin
			case (stage_q)
				ST_START: begin
					if (is_pad) begin
						stage_d = ST_PAD;
					end else if (is_shift) begin
						held_d  = req.wire_byte;
						stage_d = ST_SHIFT;
					end else begin
						ent.code[0] = {2'b00, c};
						ent.rel[0]  = rel;
						ent.count   = 2'd1;
						ent.status  = 1'b1;
					end
				end
				ST_PAD: begin
					stage_d     = ST_START;
					ent.status  = 1'b1;
					ent.code[0] = pad_code;
					ent.rel[0]  = rel;
					ent.count   = 2'd1;
					if (arrow && rel) begin
						ent.code[1] = calc_code;
						ent.rel[1]  = 1'b1;
						ent.count   = 2'd2;
					end
				end
				ST_SHIFT: begin
					if (is_pad) begin
						stage_d = ST_SHIFT_PAD;
					end else begin
						// plain shift, then the byte is read again from start
						ent.code[0] = shift_code;
						ent.rel[0]  = held_q[7];
						ent.count   = 2'd1;
						if (is_shift) begin
							held_d  = req.wire_byte;
							stage_d = ST_SHIFT;
						end else begin
							stage_d     = ST_START;
							ent.code[1] = {2'b00, c};
							ent.rel[1]  = rel;
							ent.count   = 2'd2;
							ent.status  = 1'b1;
						end
					end
				end
				default: begin
					stage_d    = ST_START;
					ent.status = 1'b1;
					if (!arrow) begin
						ent.code[0] = shift_code;
						ent.rel[0]  = held_q[7];
						ent.code[1] = pad_code;
						ent.rel[1]  = rel;
						ent.count   = 2'd2;
					end else if (held_q[7]) begin
						if (rel) begin
							ent.code[0] = pad_code;
							ent.rel[0]  = 1'b1;
							ent.code[1] = calc_code;
							ent.rel[1]  = 1'b1;
							ent.code[2] = shift_code;
							ent.rel[2]  = 1'b1;
							ent.count   = 2'd3;
						end else begin
							ent.code[0] = shift_code;
							ent.rel[0]  = 1'b1;
							ent.count   = 2'd1;
						end
					end else if (rel) begin
						ent.code[0] = pad_code;
						ent.rel[0]  = 1'b1;
						ent.code[1] = calc_code;
						ent.rel[1]  = 1'b1;
						ent.count   = 2'd2;
					end else begin
						ent.code[0] = calc_code;
						ent.count   = 2'd1;
					end
				end
			endcase
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_START;
			held_q  <= 8'd0;
		end else if (push) begin
			stage_q <= stage_d;
			held_q  <= held_d;
		end
	end

endmodule

// ----- design/kpsd_queue.sv -----
module kpsd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  kpsd_pkg::kpsd_entry_t push_data,
	input  logic                  pop,
	output kpsd_pkg::kpsd_entry_t head,
	output kpsd_pkg::kpsd_qstat_t qstat
);
	import kpsd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	kpsd_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign qstat.empty = cnt_q == '0;
	assign qstat.full  = cnt_q == CNT_W'(DEPTH);
	assign head        = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ----- design/kpsd_back.sv -----
module kpsd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kpsd_pkg::kpsd_entry_t head,
	input  kpsd_pkg::kpsd_qstat_t qstat,
	output logic                  pop,
	kpsd_rsp_if.source            rsp
);
	import kpsd_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       load, take, at_last;
	logic       valid_q;

	assign last_idx = (head.count == 2'd0) ? 2'd0 : 2'(head.count - 2'd1);
	assign at_last  = idx_q == last_idx;
	assign load     = !valid_q || rsp.ready;
	assign take     = load && !qstat.empty;
	assign pop      = take && at_last;
	assign rsp.valid = valid_q;

	// Slot walk over the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !qstat.empty;
			if (take) begin
				idx_q <= at_last ? 2'd0 : 2'(idx_q + 2'd1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (take) begin
			rsp.has_event  <= head.count != 2'd0;
			rsp.key_code   <= head.code[idx_q];
			rsp.is_release <= head.rel[idx_q];
			rsp.last       <= at_last;
			rsp.status     <= at_last && head.status;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.empty |-> idx_q <= last_idx)
		else $error("slot index past entry count");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> idx_q == 2'd0)
		else $error("slot index not cleared between items");
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status) |-> rsp.last)
		else $error("status set on a result that is not last");

endmodule

// ----- design/keyboard_prefix_shift_decoder.sv -----
// A result reaches rsp through the queue and then the output register after its item is accepted.
// Throughput: one item per cycle while each item gives one result and rsp is ready; an item that gives
// two or three events holds the back end until all are sent, one result per cycle while rsp is ready,
// through the single output register. The front stalls only when the queue is full.
// Reset (arst_n low, asynchronous): decoder at start, held shift byte zero, registers
// at their defaults, queue and output register empty.
module keyboard_prefix_shift_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	kpsd_req_if.sink   req,
	kpsd_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);
	import kpsd_pkg::*;

	logic        push, pop;
	kpsd_entry_t push_data, head;
	kpsd_qstat_t qstat;

	kpsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	kpsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	kpsd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

// ----- test/tb_keyboard_prefix_shift_decoder.sv -----
module tb_keyboard_prefix_shift_decoder;
	import kpsd_pkg::*;

	// Decoder position between wire bytes
	typedef enum logic [1:0] {
		AT_START,
		AFTER_PAD,
		AFTER_SHIFT,
		AFTER_SHIFT_PAD
	} decode_stage_e;

	typedef struct packed {
		logic       has_event;
		logic [7:0] key_code;
		logic       is_release;
		logic       status;
		logic       last;
	} key_result_t;

	localparam logic [8:0] INTR_MARK = 9'h100;

	// Shadow decoder plus the queue of key results still owed by the block
	class kpsd_scoreboard;
		logic [6:0]    pad_prefix;
		logic [6:0]    shift_mark;
		logic [7:0]    pad_offset;
		logic [7:0]    calc_offset;
		decode_stage_e stage;
		logic [7:0]    held_shift;
		key_result_t   expected_keys[$];
		key_result_t   step_keys[$];
		int            n_items;
		int            n_results;
		int            n_events;
		int            n_errors;

		function void reset_state();
			pad_prefix = 7'd121;
			shift_mark = 7'd113;
			pad_offset = 8'd64;
			calc_offset = 8'd128;
			stage = AT_START;
			held_shift = 8'h00;
			expected_keys.delete();
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				REG_PAD_PREFIX: pad_prefix = val[6:0];
				REG_SHIFT: shift_mark = val[6:0];
				REG_PAD_OFFSET: pad_offset = val;
				REG_CALC_OFFSET: calc_offset = val;
				default: ;
			endcase
		endfunction

		// at most three events per item; extras are dropped
		function void add_event(logic [7:0] code, logic rel);
			key_result_t r;
			if (step_keys.size() >= 3)
				return;
			r = '{has_event: 1'b1, key_code: code, is_release: rel, status: 1'b0, last: 1'b0};
			step_keys.push_back(r);
		endfunction

		function bit is_arrow(logic [5:0] c);
			return c inside {ARROW_A, ARROW_B, ARROW_C, ARROW_D};
		endfunction

		function void add_shift();
			add_event({2'b00, held_shift[6:1]}, held_shift[7]);
		endfunction

		function void add_arrow_release(logic [5:0] c);
			add_event(8'(pad_offset + {2'b00, c}), 1'b1);
			add_event(8'(calc_offset + {2'b00, c}), 1'b1);
		endfunction

		// returns the status; replay set when a plain shift forces a second pass
		function bit decode_byte(logic [7:0] w, output bit replay);
			logic [5:0] c;
			logic       rel;
			logic [6:0] low;
			c = w[6:1];
			rel = w[7];
			low = w[6:0];
			replay = 1'b0;
			case (stage)
				AT_START: begin
					if (low == pad_prefix) begin
						stage = AFTER_PAD;
						return 1'b0;
					end
					if (low == shift_mark) begin
						held_shift = w;
						stage = AFTER_SHIFT;
						return 1'b0;
					end
					add_event({2'b00, c}, rel);
				end
				AFTER_PAD: begin
					stage = AT_START;
					if (is_arrow(c) && rel)
						add_arrow_release(c);
					else
						add_event(8'(pad_offset + {2'b00, c}), rel);
				end
				AFTER_SHIFT: begin
					if (low == pad_prefix) begin
						stage = AFTER_SHIFT_PAD;
						return 1'b0;
					end
					add_shift();
					stage = AT_START;
					replay = 1'b1;
				end
				default: begin
					stage = AT_START;
					if (!is_arrow(c)) begin
						add_shift();
						add_event(8'(pad_offset + {2'b00, c}), rel);
					end else if (held_shift[7]) begin
						// shift released around the arrow
						if (rel)
							add_arrow_release(c);
						add_shift();
					end else if (rel) begin
						add_arrow_release(c);
					end else begin
						add_event(8'(calc_offset + {2'b00, c}), 1'b0);
					end
				end
			endcase
			return 1'b1;
		endfunction

		function void decode_wire_item(logic rt, logic [7:0] w);
			bit          again;
			bit          dummy;
			bit          st;
			key_result_t r;
			step_keys.delete();
			if (rt) begin
				// interrupted transfer flushes any held shift
				if (stage == AFTER_SHIFT || stage == AFTER_SHIFT_PAD)
					add_shift();
				stage = AT_START;
				st = 1'b1;
			end else begin
				st = decode_byte(w, again);
				if (again)
					st = decode_byte(w, dummy);
			end
			if (step_keys.size() == 0)
				step_keys.push_back('0);
			r = step_keys.pop_back();
			r.status = st;
			r.last = 1'b1;
			step_keys.push_back(r);
			foreach (step_keys[i])
				expected_keys.push_back(step_keys[i]);
			n_items++;
		endfunction

		function void check_key_result(key_result_t got);
			key_result_t want;
			if (expected_keys.size() == 0) begin
				n_errors++;
				$display("%0t: key result with nothing expected:", $time);
				$display("  actual   ev=%0b code=%02h rel=%0b st=%0b last=%0b",
					got.has_event, got.key_code, got.is_release, got.status, got.last);
				return;
			end
			want = expected_keys.pop_front();
			n_results++;
			if (want.has_event)
				n_events++;
			if (got.has_event !== want.has_event || got.key_code !== want.key_code ||
				got.is_release !== want.is_release || got.status !== want.status ||
				got.last !== want.last) begin
				n_errors++;
				$display("%0t: key result mismatch", $time);
				$display("  expected ev=%0b code=%02h rel=%0b st=%0b last=%0b",
					want.has_event, want.key_code, want.is_release, want.status, want.last);
				$display("  actual   ev=%0b code=%02h rel=%0b st=%0b last=%0b",
					got.has_event, got.key_code, got.is_release, got.status, got.last);
			end
		endfunction

		function void drop_leftovers();
			if (expected_keys.size() != 0) begin
				n_errors += expected_keys.size();
				$display("%0t: %0d expected key results never arrived", $time,
					expected_keys.size());
				expected_keys.delete();
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_wdata;

	kpsd_req_if req();
	kpsd_rsp_if rsp();

	kpsd_scoreboard board;
	key_result_t    got_key;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             stall_asked;
	int             stall_seen;
	int             stall_left;
	int             items_sent;

	keyboard_prefix_shift_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Run limit
	initial begin
		#2400000;
		$display("** keyboard_prefix_shift_decoder: FAILED **");
		$finish;
	end

	// Receiver: random back-pressure, plus long hold-offs on request
	always @(posedge clk) begin
		if (stall_seen != stall_asked) begin
			stall_seen = stall_asked;
			stall_left = 80;
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Item monitors
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			board.decode_wire_item(req.req_type, req.wire_byte);
		if (arst_n && rsp.valid && rsp.ready) begin
			got_key = '{has_event: rsp.has_event, key_code: rsp.key_code,
				is_release: rsp.is_release, status: rsp.status, last: rsp.last};
			board.check_key_result(got_key);
		end
	end

	task automatic send_item(input logic rt, input logic [7:0] wb);
		req.valid <= 1'b1;
		req.req_type <= rt;
		req.wire_byte <= wb;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		items_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] wb);
		send_item(1'b0, wb);
	endtask

	task automatic send_intr();
		send_item(1'b1, 8'($urandom_range(255)));
	endtask

	task automatic write_regs(input logic [7:0] pad_v, input logic [7:0] shift_v,
		input logic [7:0] pad_off, input logic [7:0] calc_off);
		logic [7:0] vals[4];
		logic [1:0] idx[4];
		vals = '{pad_v, shift_v, pad_off, calc_off};
		idx = '{REG_PAD_PREFIX, REG_SHIFT, REG_PAD_OFFSET, REG_CALC_OFFSET};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= vals[i];
			board.write_reg(idx[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every owed result, bounded, then let the pipeline settle
	task automatic wait_drained();
		int waited;
		waited = 0;
		req.valid <= 1'b0;
		while (board.expected_keys.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		board.drop_leftovers();
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [7:0] key_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] arrow_byte();
		logic [5:0] c;
		case ($urandom_range(3))
			0: c = ARROW_A;
			1: c = ARROW_B;
			2: c = ARROW_C;
			default: c = ARROW_D;
		endcase
		return {1'($urandom_range(1)), c, 1'($urandom_range(1))};
	endfunction

	function automatic logic [7:0] pad_byte();
		return {1'($urandom_range(1)), board.pad_prefix};
	endfunction

	function automatic logic [7:0] shift_byte();
		return {1'($urandom_range(1)), board.shift_mark};
	endfunction

	// Mostly well-formed prefix/shift sequences, some noise and cut-off ones
	task automatic run_random(input int count, input int stall_at);
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < count) begin
			if (stall_at >= 0 && items_sent - start >= stall_at) begin
				stall_asked <= stall_asked + 1;
				stall_at = -1;
			end
			pick = $urandom_range(99);
			if (pick < 14) begin
				send_byte(key_byte());
			end else if (pick < 26) begin
				send_byte(pad_byte());
				send_byte(key_byte());
			end else if (pick < 38) begin
				send_byte(pad_byte());
				send_byte(arrow_byte());
			end else if (pick < 50) begin
				send_byte(shift_byte());
				send_byte(key_byte());
			end else if (pick < 62) begin
				send_byte(shift_byte());
				send_byte(pad_byte());
				send_byte(key_byte());
			end else if (pick < 78) begin
				send_byte(shift_byte());
				send_byte(pad_byte());
				send_byte(arrow_byte());
			end else if (pick < 84) begin
				send_byte(shift_byte());
				if ($urandom_range(1))
					send_byte(pad_byte());
				send_intr();
			end else if (pick < 90) begin
				send_byte(pad_byte());
				send_intr();
			end else if (pick < 94) begin
				send_intr();
			end else begin
				send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		logic [8:0] directed_q[$];
		logic [7:0] r;
		board = new();
		board.reset_state();
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.wire_byte = 8'h00;
		rsp.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PAD_PREFIX;
		cfg_wdata = 8'h00;
		stall_asked = 0;
		stall_seen = 0;
		stall_left = 0;
		items_sent = 0;
		send_idle_pct = 10;
		recv_idle_pct = 45;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed at reset settings: pad prefix 0x79, shift 0x71
		directed_q = '{
			9'h071, 9'h000,          // plain shift, replayed key code 0
			9'h0FF,                  // key code 63 released
			9'h0F9, 9'h09B,          // pad arrow release: pad and calc releases
			9'h0F1, 9'h079, 9'h020,  // shift, pad, non-arrow
			9'h0F1, 9'h079, 9'h08D,  // released shift, pad, arrow release
			9'h0F1, 9'h079, 9'h005,  // released shift, pad, arrow press
			9'h071, 9'h079, 9'h011,  // pressed shift, pad, arrow press
			9'h071, 9'h079, 9'h085,  // pressed shift, pad, arrow release
			9'h071, INTR_MARK,       // held shift flushed by interrupt
			9'h0F1, 9'h071, 9'h0FE,  // shift replaced by a second shift
			9'h079, INTR_MARK,       // pending pad prefix dropped
			INTR_MARK
		};
		foreach (directed_q[i]) begin
			if (directed_q[i] == INTR_MARK)
				send_intr();
			else
				send_byte(directed_q[i][7:0]);
		end
		wait_drained();

		// Extremes; upper bit of the 7-bit registers must be masked off
		write_regs(8'h80, 8'hFF, 8'hFF, 8'hFF);
		run_random(100, 40);
		wait_drained();

		send_idle_pct <= 45;
		recv_idle_pct <= 10;
		write_regs(8'h7F, 8'h00, 8'h00, 8'h00);
		run_random(100, -1);
		wait_drained();

		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		write_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
		run_random(90, -1);
		wait_drained();

		// Pad prefix and shift share one value: prefix wins at start
		r = 8'($urandom_range(255));
		write_regs(r | 8'h80, r, 8'($urandom_range(255)), 8'($urandom_range(255)));
		run_random(40, -1);
		wait_drained();

		write_regs(8'd121, 8'd113, 8'd64, 8'd128);
		run_random(20, -1);
		wait_drained();

		$display("Sent %0d wire items over six register settings and three idling mixes;",
			board.n_items);
		$display("checked %0d key results, %0d of them carrying events; %0d errors.",
			board.n_results, board.n_events, board.n_errors);
		if (board.n_errors == 0)
			$display("** keyboard_prefix_shift_decoder: PASSED **");
		else
			$display("** keyboard_prefix_shift_decoder: FAILED **");
		$finish;
	end
endmodule
